/* rtl/core/fba_pkg.sv */
`timescale 1ns / 1ps

package fba_pkg;

    // bitmap words: one used word and one bad word per memory row
    localparam int WORD_BITS = 32;
    localparam int LANE_W    = 5;
    localparam int BLK_W     = 11;
    localparam int PAGE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int LIMIT_W   = 16;
    localparam int WEAR_W    = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd5000;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK_USED   = 3'd0,
        CMD_MARK_FREE   = 3'd1,
        CMD_QUERY_AVAIL = 3'd2,
        CMD_FIND        = 3'd3,
        CMD_RECORD      = 3'd4,
        CMD_QUERY_PAGE  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        WOP_SET_USED,
        WOP_CLR_USED,
        WOP_SET_BAD
    } t_word_op;

    typedef struct packed {
        logic [WORD_BITS-1:0] bad;
        logic [WORD_BITS-1:0] used;
    } t_bm_word;

    typedef struct packed {
        logic             hit;
        logic [BLK_W-1:0] block;
    } t_scan_res;

    // last field in the lowest bits
    typedef struct packed {
        logic              range_error;
        logic [WEAR_W-1:0] wear_count;
        logic              page_rotten;
        logic [BLK_W-1:0]  found_block;
        logic              found;
        logic              available;
    } t_result;

endpackage

/* rtl/core/fba_word_unit.sv */
`timescale 1ns / 1ps

module fba_word_unit import fba_pkg::*; #(
    parameter int NUM_BLOCKS = 2048,
    parameter int WADDR_W    = 6
) (
    input  t_word_op            i_op,
    input  t_bm_word            i_word,
    input  logic [WADDR_W-1:0]  i_word_idx,
    input  logic [LANE_W-1:0]   i_lane,
    output t_bm_word            o_word,
    output logic                o_used_bit,
    output t_scan_res           o_scan
);

    logic [WORD_BITS-1:0] cand;
    logic [LANE_W-1:0]    first_lane;
    logic [31:0]          blk_full;

    // usable lanes: free, not bad, and a real block other than block zero
    always_comb begin
        logic [31:0] idx;
        for (int j = 0; j < WORD_BITS; j++) begin
            idx     = 32'({i_word_idx, LANE_W'(j)});
            cand[j] = (idx >= 32'd1) && (idx < 32'(NUM_BLOCKS))
                      && !i_word.used[j] && !i_word.bad[j];
        end
    end

    // lowest lane wins
    always_comb begin
        first_lane = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                first_lane = LANE_W'(j);
            end
        end
    end

    assign blk_full      = 32'({i_word_idx, first_lane});
    assign o_scan.hit    = |cand;
    assign o_scan.block  = o_scan.hit ? blk_full[BLK_W-1:0] : '0;
    assign o_used_bit    = i_word.used[i_lane];

    always_comb begin
        o_word = i_word;
        case (i_op)
            WOP_SET_USED: o_word.used[i_lane] = 1'b1;
            WOP_CLR_USED: o_word.used[i_lane] = 1'b0;
            WOP_SET_BAD:  o_word.bad[i_lane]  = 1'b1;
            default:      o_word = i_word;
        endcase
    end

endmodule

/* rtl/core/fba_wear_unit.sv */
`timescale 1ns / 1ps

module fba_wear_unit import fba_pkg::*; #(
    parameter int WEAR_BITS = 16
) (
    input  logic [WEAR_BITS-1:0] i_count,
    input  logic [LIMIT_W-1:0]   i_limit,
    output logic [WEAR_BITS-1:0] o_count,
    output logic                 o_rotten
);

    // saturate at full scale
    assign o_count  = (i_count == '1) ? i_count : i_count + 1'b1;
    assign o_rotten = 32'(o_count) >= 32'(i_limit);

endmodule

/* rtl/core/flash_block_allocator_wear.sv */
`timescale 1ns / 1ps
// Mark used / mark free / query available / record erase / query page: the row is read
// (wait state), then used (use state), and the result is registered; next word taken after that.
// Find usable: one bitmap row per cycle, result registered once a usable block is hit or
// the last row is checked; the rate is set by the single bitmap memory read port.
// Reset starts a clearing pass over the wear memory and bitmap; no word is taken
// until it ends.

module flash_block_allocator_wear import fba_pkg::*; #(
    parameter int NUM_BLOCKS  = 2048,
    parameter int BLOCK_PAGES = 256,
    parameter int WEAR_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,      // erase_limit
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [23:0]          i_s_axis_tdata,   // command, block_index, page_in_block
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // available, found, found_block, page_rotten, wear_count, range_error
    output logic [31:0]          o_m_axis_tdata
);

    localparam int NWORDS    = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int TOTAL     = NUM_BLOCKS * BLOCK_PAGES;
    localparam int PADDR_W   = $clog2(TOTAL);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
    localparam logic [PADDR_W-1:0] LAST_PAGE = PADDR_W'(TOTAL - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BM_WAIT,
        ST_BM_USE,
        ST_SCAN,
        ST_PG_WAIT,
        ST_PG_USE,
        ST_DONE
    } t_state;

    t_state               r_state,      n_state;
    t_cmd                 r_cmd,        n_cmd;
    logic [LANE_W-1:0]    r_lane,       n_lane;
    logic [WADDR_W-1:0]   r_baddr,      n_baddr;
    logic [PADDR_W-1:0]   r_paddr,      n_paddr;
    logic [WADDR_W-1:0]   r_chk_word,   n_chk_word;
    logic                 r_chk_vld,    n_chk_vld;
    t_result              r_res,        n_res;
    logic                 r_out_valid,  n_out_valid;
    t_result              r_out_data,   n_out_data;
    logic [LIMIT_W-1:0]   r_erase_limit;

    t_bm_word             bm_mem [NWORDS];
    logic [WEAR_BITS:0]   wear_mem [TOTAL];
    t_bm_word             r_bm_rd;
    logic [WEAR_BITS:0]   r_wm_rd;

    logic                 bm_we;
    logic [WADDR_W-1:0]   bm_waddr;
    t_bm_word             bm_wdata;
    logic                 wm_we;
    logic [WEAR_BITS:0]   wm_wdata;

    t_word_op             wop;
    t_bm_word             word_new;
    logic                 used_bit;
    t_scan_res            scan;

    logic [WEAR_BITS-1:0] new_count;
    logic                 new_rot;
    logic [31:0]          new_count_ext;
    logic [31:0]          cur_count_ext;

    t_cmd                 in_cmd;
    logic [BLK_W-1:0]     in_blk;
    logic [PAGE_W-1:0]    in_pg;
    logic                 in_blk_ok;
    logic                 in_pg_ok;
    logic [31:0]          in_word_full;
    logic [31:0]          in_paddr_full;

    assign in_cmd        = t_cmd'(i_s_axis_tdata[2:0]);
    assign in_blk        = i_s_axis_tdata[13:3];
    assign in_pg         = i_s_axis_tdata[21:14];
    assign in_blk_ok     = 32'(in_blk) < 32'(NUM_BLOCKS);
    assign in_pg_ok      = 32'(in_pg) < 32'(BLOCK_PAGES);
    assign in_word_full  = 32'(in_blk) >> LANE_W;
    assign in_paddr_full = 32'(in_blk) * 32'(BLOCK_PAGES) + 32'(in_pg);

    assign new_count_ext = 32'(new_count);
    assign cur_count_ext = 32'(r_wm_rd[WEAR_BITS-1:0]);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

    fba_word_unit #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WADDR_W    (WADDR_W)
    ) u_word (
        .i_op       (wop),
        .i_word     (r_bm_rd),
        .i_word_idx (r_chk_word),
        .i_lane     (r_lane),
        .o_word     (word_new),
        .o_used_bit (used_bit),
        .o_scan     (scan)
    );

    fba_wear_unit #(
        .WEAR_BITS (WEAR_BITS)
    ) u_wear (
        .i_count  (r_wm_rd[WEAR_BITS-1:0]),
        .i_limit  (r_erase_limit),
        .o_count  (new_count),
        .o_rotten (new_rot)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_lane      = r_lane;
        n_baddr     = r_baddr;
        n_paddr     = r_paddr;
        n_chk_word  = r_chk_word;
        n_chk_vld   = r_chk_vld;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wop         = WOP_SET_USED;
        bm_we       = 1'b0;
        bm_waddr    = r_baddr;
        bm_wdata    = word_new;
        wm_we       = 1'b0;
        wm_wdata    = {new_rot, new_count};

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // sweep the wear memory, bitmap rows ride along on the same count
                wm_we    = 1'b1;
                wm_wdata = '0;
                bm_waddr = r_paddr[WADDR_W-1:0];
                bm_wdata = '0;
                if (32'(r_paddr) < 32'(NWORDS)) begin
                    bm_we = 1'b1;
                end
                if (r_paddr == LAST_PAGE) begin
                    n_state = ST_IDLE;
                end else begin
                    n_paddr = r_paddr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd     = in_cmd;
                    n_lane    = in_blk[LANE_W-1:0];
                    n_res     = '0;
                    n_chk_vld = 1'b0;
                    if (in_blk_ok) begin
                        n_baddr = in_word_full[WADDR_W-1:0];
                    end
                    if (in_blk_ok && in_pg_ok) begin
                        n_paddr = in_paddr_full[PADDR_W-1:0];
                    end
                    case (in_cmd)
                        CMD_MARK_USED, CMD_MARK_FREE: begin
                            if (in_blk_ok) begin
                                n_state = ST_BM_WAIT;
                            end else begin
                                n_res.range_error = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        CMD_QUERY_AVAIL: begin
                            if (in_blk_ok && in_blk != '0) begin
                                n_state = ST_BM_WAIT;
                            end else begin
                                n_res.range_error = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        CMD_FIND: begin
                            n_baddr = '0;
                            n_state = ST_SCAN;
                        end
                        CMD_RECORD, CMD_QUERY_PAGE: begin
                            if (in_blk_ok && in_pg_ok) begin
                                n_state = ST_PG_WAIT;
                            end else begin
                                n_res.range_error = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_BM_WAIT: n_state = ST_BM_USE;
            ST_BM_USE: begin
                case (r_cmd)
                    CMD_MARK_USED: begin
                        wop   = WOP_SET_USED;
                        bm_we = 1'b1;
                    end
                    CMD_MARK_FREE: begin
                        wop   = WOP_CLR_USED;
                        bm_we = 1'b1;
                    end
                    default: n_res.available = !used_bit;
                endcase
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // issue one row a cycle, check the row read the cycle before
                if (r_baddr != LAST_WORD) begin
                    n_baddr = r_baddr + 1'b1;
                end
                n_chk_word = r_baddr;
                n_chk_vld  = 1'b1;
                if (r_chk_vld) begin
                    if (scan.hit) begin
                        n_res.found       = 1'b1;
                        n_res.found_block = scan.block;
                        n_state           = ST_DONE;
                    end else if (r_chk_word == LAST_WORD) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PG_WAIT: n_state = ST_PG_USE;
            ST_PG_USE: begin
                if (r_cmd == CMD_RECORD && !r_wm_rd[WEAR_BITS]) begin
                    wm_we             = 1'b1;
                    n_res.page_rotten = new_rot;
                    n_res.wear_count  = new_count_ext[WEAR_W-1:0];
                    if (new_rot) begin
                        // bitmap row of this block was read alongside the page
                        wop   = WOP_SET_BAD;
                        bm_we = 1'b1;
                    end
                end else begin
                    n_res.page_rotten = r_wm_rd[WEAR_BITS];
                    n_res.wear_count  = cur_count_ext[WEAR_W-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_paddr       <= '0;
            r_chk_vld     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_erase_limit <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_lane      <= n_lane;
            r_baddr     <= n_baddr;
            r_paddr     <= n_paddr;
            r_chk_word  <= n_chk_word;
            r_chk_vld   <= n_chk_vld;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            if (i_cfg_we) begin
                r_erase_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        r_bm_rd <= bm_mem[r_baddr];
    end

    always_ff @(posedge i_clk) begin
        if (wm_we) begin
            wear_mem[r_paddr] <= wm_wdata;
        end
        r_wm_rd <= wear_mem[r_paddr];
    end

endmodule

/* rtl/core/fba_checker.sv */
`timescale 1ns / 1ps

module fba_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] o_m_axis_tdata
);

    // out of reset: clearing pass runs, nothing pending
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("busy or result pending straight after reset");

    // one word at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready held high after a word was taken");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a range error carries no other answer
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[30] |-> o_m_axis_tdata[29:0] == 30'd0)
        else $error("range error with non-zero fields");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[1] |-> o_m_axis_tdata[12:2] == 11'd0)
        else $error("block number given without a find hit");

endmodule

bind flash_block_allocator_wear fba_checker u_fba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
